[rtl/cbpb_pkg.sv]
// ----------------------------------------------------------------------------
// cbpb_pkg - shared types and constants for the centred bitmap blitter
// Request payload types, configuration bundle, register indices and
// pixel format codes used by every module of the blitter.
// ----------------------------------------------------------------------------
package cbpb_pkg;

	// field widths
	localparam int DIM_W       = 13;
	localparam int STRIDE_W    = 15;
	localparam int DEPTH_W     = 6;
	localparam int COUNT_W     = 12;
	localparam int ADDR_W      = 26;
	localparam int VALUE_W     = 24;
	localparam int BYTES_W     = 3;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 15;

	// register indices
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_BOTTOM   = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_STRIDE   = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEST_DEPTH    = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_RED_AT_BIT16  = 4'd7;

	// destination formats
	localparam logic [DEPTH_W-1:0] DEPTH_16 = 6'd16;
	localparam logic [DEPTH_W-1:0] DEPTH_32 = 6'd32;
	localparam logic [BYTES_W-1:0] BYTES_16 = 3'd2;
	localparam logic [BYTES_W-1:0] BYTES_32 = 3'd4;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  byte_address;
		logic [VALUE_W-1:0] pixel_value;
		logic [BYTES_W-1:0] pixel_bytes;
	} pix_out_t;

	typedef struct packed {
		logic [DIM_W-1:0]    image_width;
		logic [DIM_W-1:0]    image_height;
		logic                rows_bottom_up;
		logic [DIM_W-1:0]    screen_width;
		logic [DIM_W-1:0]    screen_height;
		logic [STRIDE_W-1:0] line_stride_bytes;
		logic [DEPTH_W-1:0]  dest_depth;
		logic                red_at_bit16;
	} cfg_t;

	// placed pixel between the placement stage and the address stage
	typedef struct packed {
		logic [COUNT_W-1:0] dst_x;
		logic [COUNT_W-1:0] dst_y;
		logic [VALUE_W-1:0] pixel_value;
		logic               wide;
	} place_t;

endpackage

[rtl/cbpb_cfg.sv]
// ----------------------------------------------------------------------------
// cbpb_cfg - configuration register file
// Holds the eight blitter registers, saturating sizes and stride on write.
// ----------------------------------------------------------------------------
module cbpb_cfg #(
	parameter int MAX_DIMENSION    = 4096,
	parameter int MAX_STRIDE_BYTES = 16384
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cbpb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [cbpb_pkg::CFG_DATA_W-1:0]     cfg_data,
	output cbpb_pkg::cfg_t                      cfg
);

	cbpb_pkg::cfg_t cfg_q;
	logic [cbpb_pkg::DIM_W-1:0]    dim_raw;
	logic [cbpb_pkg::DIM_W-1:0]    dim_sat;
	logic [cbpb_pkg::STRIDE_W-1:0] stride_raw;
	logic [cbpb_pkg::STRIDE_W-1:0] stride_sat;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// saturate sizes into [1, max]
	assign dim_raw    = cfg_data[cbpb_pkg::DIM_W-1:0];
	assign stride_raw = cfg_data[cbpb_pkg::STRIDE_W-1:0];

	always_comb begin
		if (dim_raw == '0) begin
			dim_sat = cbpb_pkg::DIM_W'(1);
		end else if (int'(dim_raw) > MAX_DIMENSION) begin
			dim_sat = cbpb_pkg::DIM_W'(MAX_DIMENSION);
		end else begin
			dim_sat = dim_raw;
		end
		if (stride_raw == '0) begin
			stride_sat = cbpb_pkg::STRIDE_W'(1);
		end else if (int'(stride_raw) > MAX_STRIDE_BYTES) begin
			stride_sat = cbpb_pkg::STRIDE_W'(MAX_STRIDE_BYTES);
		end else begin
			stride_sat = stride_raw;
		end
	end

	// register writes; unknown indices are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width       <= cbpb_pkg::DIM_W'(1);
			cfg_q.image_height      <= cbpb_pkg::DIM_W'(1);
			cfg_q.rows_bottom_up    <= 1'b1;
			cfg_q.screen_width      <= cbpb_pkg::DIM_W'(1);
			cfg_q.screen_height     <= cbpb_pkg::DIM_W'(1);
			cfg_q.line_stride_bytes <= cbpb_pkg::STRIDE_W'(1);
			cfg_q.dest_depth        <= cbpb_pkg::DEPTH_32;
			cfg_q.red_at_bit16      <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				cbpb_pkg::CFG_IMAGE_WIDTH:   cfg_q.image_width       <= dim_sat;
				cbpb_pkg::CFG_IMAGE_HEIGHT:  cfg_q.image_height      <= dim_sat;
				cbpb_pkg::CFG_ROWS_BOTTOM:   cfg_q.rows_bottom_up    <= cfg_data[0];
				cbpb_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width      <= dim_sat;
				cbpb_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height     <= dim_sat;
				cbpb_pkg::CFG_LINE_STRIDE:   cfg_q.line_stride_bytes <= stride_sat;
				cbpb_pkg::CFG_DEST_DEPTH: begin
					cfg_q.dest_depth <= cfg_data[cbpb_pkg::DEPTH_W-1:0];
				end
				cbpb_pkg::CFG_RED_AT_BIT16:  cfg_q.red_at_bit16      <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/cbpb_place.sv]
// ----------------------------------------------------------------------------
// cbpb_place - pixel counters, clipping, centring and colour packing
// Captures each request with its column and row, then decides visibility,
// screen coordinates and the packed colour for the address stage.
// ----------------------------------------------------------------------------
module cbpb_place (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cbpb_pkg::cfg_t        cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cbpb_pkg::pix_in_t     in_data,
	output logic                  place_valid,
	input  logic                  place_take,
	output cbpb_pkg::place_t      place_data
);

	localparam int DW = cbpb_pkg::DIM_W;
	localparam int CW = cbpb_pkg::COUNT_W;

	logic [CW-1:0]     col_q, row_q;
	logic [DW-1:0]     col_next, row_next;
	logic              in_take;

	logic              valid_s1;
	cbpb_pkg::pix_in_t pix_s1;
	logic [CW-1:0]     col_s1, row_s1;
	logic              move_s1;

	logic              valid_s2;
	cbpb_pkg::place_t  data_s2;

	logic [DW-1:0]     draw_w, draw_h, off_x, off_y, y_img, sum_x, sum_y;
	logic              visible, on_screen, write;
	cbpb_pkg::place_t  placed;

	assign in_take  = in_valid && in_ready;
	assign move_s1  = valid_s1 && (!valid_s2 || place_take);
	assign in_ready = !valid_s1 || move_s1;

	// column and row counters, wrapping at the image size
	assign col_next = {1'b0, col_q} + DW'(1);
	assign row_next = {1'b0, row_q} + DW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_take) begin
			if (col_next >= cfg.image_width) begin
				col_q <= '0;
				if (row_next >= cfg.image_height) begin
					row_q <= '0;
				end else begin
					row_q <= row_next[CW-1:0];
				end
			end else begin
				col_q <= col_next[CW-1:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pix_s1 <= in_data;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	// clip and centre
	always_comb begin
		draw_w  = (cfg.image_width  < cfg.screen_width)  ? cfg.image_width  : cfg.screen_width;
		draw_h  = (cfg.image_height < cfg.screen_height) ? cfg.image_height : cfg.screen_height;
		off_x   = (cfg.screen_width  - draw_w) >> 1;
		off_y   = (cfg.screen_height - draw_h) >> 1;
		visible = ({1'b0, col_s1} < cfg.image_width) && ({1'b0, row_s1} < cfg.image_height);
		y_img   = cfg.rows_bottom_up ? (cfg.image_height - DW'(1) - {1'b0, row_s1})
		                             : {1'b0, row_s1};
		on_screen = visible && ({1'b0, col_s1} < draw_w) && (y_img < draw_h);
		write   = on_screen && ((cfg.dest_depth == cbpb_pkg::DEPTH_32) ||
		                        (cfg.dest_depth == cbpb_pkg::DEPTH_16));
		sum_x   = off_x + {1'b0, col_s1};
		sum_y   = off_y + y_img;

		placed.dst_x = sum_x[CW-1:0];
		placed.dst_y = sum_y[CW-1:0];
		placed.wide  = (cfg.dest_depth == cbpb_pkg::DEPTH_32);
		if (cfg.dest_depth == cbpb_pkg::DEPTH_32) begin
			if (cfg.red_at_bit16) begin
				placed.pixel_value = {pix_s1.red, pix_s1.green, pix_s1.blue};
			end else begin
				placed.pixel_value = {pix_s1.blue, pix_s1.green, pix_s1.red};
			end
		end else begin
			// RGB565
			placed.pixel_value = {8'd0, pix_s1.red[7:3], pix_s1.green[7:2],
			                      pix_s1.blue[7:3]};
		end
	end

	// placement register; pixels off screen leave no request behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= write;
		end else if (place_take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			data_s2 <= placed;
		end
	end

	assign place_valid = valid_s2;
	assign place_data  = data_s2;

endmodule

[rtl/cbpb_addr.sv]
// ----------------------------------------------------------------------------
// cbpb_addr - framebuffer address and output register
// Forms dst_y * stride + dst_x * bytes and holds the finished write request.
// ----------------------------------------------------------------------------
module cbpb_addr (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [cbpb_pkg::STRIDE_W-1:0]      line_stride_bytes,
	input  logic                               place_valid,
	output logic                               place_take,
	input  cbpb_pkg::place_t                   place_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output cbpb_pkg::pix_out_t                 out_data
);

	localparam int CW   = cbpb_pkg::COUNT_W;
	localparam int PW   = CW + cbpb_pkg::STRIDE_W;
	localparam int AW   = cbpb_pkg::ADDR_W;

	logic [PW-1:0]       row_offset;
	logic [CW+1:0]       col_offset;
	logic [PW:0]         addr_sum;
	cbpb_pkg::pix_out_t  result;
	logic                out_valid_q;
	cbpb_pkg::pix_out_t  out_data_q;

	assign place_take = place_valid && (!out_valid_q || out_ready);

	// row start times stride, plus column scaled by pixel size
	always_comb begin
		row_offset = PW'(place_data.dst_y) * PW'(line_stride_bytes);
		col_offset = place_data.wide ? {place_data.dst_x, 2'b00}
		                             : {1'b0, place_data.dst_x, 1'b0};
		addr_sum   = {1'b0, row_offset} + (PW+1)'(col_offset);
		result.byte_address = addr_sum[AW-1:0];
		result.pixel_value  = place_data.pixel_value;
		result.pixel_bytes  = place_data.wide ? cbpb_pkg::BYTES_32 : cbpb_pkg::BYTES_16;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (place_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (place_take) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/centered_bitmap_pixel_blitter_unit.sv]
// ----------------------------------------------------------------------------
// centered_bitmap_pixel_blitter_unit - centred bitmap to framebuffer blitter
// Turns a stream of source bitmap pixels into framebuffer write requests.
//
// Input channel (in_valid/in_ready/in_data): one blue/green/red pixel per
// request, in file order. Column and row counters place each pixel; the image
// is clipped to the screen and centred, and only visible pixels in a 16 or
// 32 bit destination depth produce a request on the output channel
// (out_valid/out_ready/out_data) with byte address, packed value and size.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; write it only while no pixel is in flight. Writes leave the
// counters alone.
//
// An accepted pixel passes the input register, loaded at the accepting edge,
// then the placement register, then the output register with the stride
// multiplier in front, which raises out_valid. Throughput: one pixel per
// cycle while out_ready stays high. Reset clears the counters, empties the
// pipeline and loads the register defaults. A stalled receiver holds the
// output request; the pipeline fills up behind it and in_ready drops once
// all three stages are occupied.
// ----------------------------------------------------------------------------
module centered_bitmap_pixel_blitter_unit #(
	parameter int MAX_DIMENSION    = 4096,
	parameter int MAX_STRIDE_BYTES = 16384
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cbpb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cbpb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  cbpb_pkg::pix_in_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output cbpb_pkg::pix_out_t               out_data
);

	cbpb_pkg::cfg_t   cfg;
	logic             place_valid;
	logic             place_take;
	cbpb_pkg::place_t place_data;

	// register file
	cbpb_cfg #(
		.MAX_DIMENSION    (MAX_DIMENSION),
		.MAX_STRIDE_BYTES (MAX_STRIDE_BYTES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// counters, clipping and packing
	cbpb_place u_place (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.place_valid (place_valid),
		.place_take  (place_take),
		.place_data  (place_data)
	);

	// address and output register
	cbpb_addr u_addr (
		.clk               (clk),
		.arst_n            (arst_n),
		.line_stride_bytes (cfg.line_stride_bytes),
		.place_valid       (place_valid),
		.place_take        (place_take),
		.place_data        (place_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_data          (out_data)
	);

	// input only stalls when the output is blocked
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && place_valid))
		else $error("input stalled without output back-pressure");

	// request size is always 2 or 4 bytes
	a_bytes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pixel_bytes == cbpb_pkg::BYTES_16 ||
		               out_data.pixel_bytes == cbpb_pkg::BYTES_32))
		else $error("illegal pixel size");

	// RGB565 occupies only the low 16 bits
	a_rgb565_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.pixel_bytes == cbpb_pkg::BYTES_16)
			|-> (out_data.pixel_value[23:16] == 8'd0))
		else $error("16-bit pixel with upper bits set");

	// a placed pixel is moved into a free or draining output register
	a_place_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(place_valid && !out_valid) |-> place_take)
		else $error("placed pixel not taken by empty output stage");

endmodule

[sim/blit_write_checker.sv]
// ----------------------------------------------------------------------------
// blit_write_checker - framebuffer write predictor and scoreboard
// Watches the configuration, pixel and write channels of the blitter. It
// keeps its own copy of the registers and the column/row counters, and works
// out the framebuffer write that each accepted pixel request should cause.
// Each accepted write request is compared field by field with the oldest
// predicted write.
// ----------------------------------------------------------------------------
module blit_write_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [cbpb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cbpb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  cbpb_pkg::pix_in_t                in_data,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  cbpb_pkg::pix_out_t               out_data,
	output int                               error_count,
	output int                               pending_writes,
	output int                               checked_writes
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM_W       = cbpb_pkg::DIM_W;
	localparam int STRIDE_W    = cbpb_pkg::STRIDE_W;
	localparam int DEPTH_W     = cbpb_pkg::DEPTH_W;
	localparam int COUNT_W     = cbpb_pkg::COUNT_W;
	localparam int ADDR_W      = cbpb_pkg::ADDR_W;
	localparam int VALUE_W     = cbpb_pkg::VALUE_W;
	localparam int BYTES_W     = cbpb_pkg::BYTES_W;
	localparam int CFG_INDEX_W = cbpb_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W  = cbpb_pkg::CFG_DATA_W;

	localparam int MAX_DIM    = 4096;
	localparam int MAX_STRIDE = 16384;
	localparam int REPORT_MAX = 10;

	// register copy
	logic [DIM_W-1:0]    img_w, img_h, scr_w, scr_h;
	logic [STRIDE_W-1:0] stride;
	logic [DEPTH_W-1:0]  depth;
	logic                flip_rows, red16;

	// source position of the next pixel
	logic [COUNT_W-1:0] src_col, src_row;

	cbpb_pkg::pix_out_t expected_writes[$];
	int                 errs, checked;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		if (v > MAX_DIM)
			return DIM_W'(MAX_DIM);
		return v;
	endfunction

	function automatic logic [STRIDE_W-1:0] clamp_stride(input logic [STRIDE_W-1:0] v);
		if (v == '0)
			return STRIDE_W'(1);
		if (v > MAX_STRIDE)
			return STRIDE_W'(MAX_STRIDE);
		return v;
	endfunction

	// place one source pixel, advance the counters, queue its write if visible
	function automatic void place_pixel(input cbpb_pkg::pix_in_t px);
		logic [DIM_W-1:0]   draw_w, draw_h, off_x, off_y, y;
		logic [COUNT_W-1:0] col, row;
		logic [BYTES_W-1:0] nbytes;
		logic [VALUE_W-1:0] value;
		logic [47:0]        addr;
		cbpb_pkg::pix_out_t wr;
		col    = src_col;
		row    = src_row;
		draw_w = (img_w < scr_w) ? img_w : scr_w;
		draw_h = (img_h < scr_h) ? img_h : scr_h;
		off_x  = (scr_w - draw_w) >> 1;
		off_y  = (scr_h - draw_h) >> 1;

		// counters wrap at the image size, also when already past it
		if (32'(col) + 1 >= 32'(img_w)) begin
			src_col = '0;
			if (32'(row) + 1 >= 32'(img_h))
				src_row = '0;
			else
				src_row = row + 1'b1;
		end else begin
			src_col = col + 1'b1;
		end

		if (col >= img_w || row >= img_h)
			return;
		y = flip_rows ? (img_h - 13'd1 - 13'(row)) : 13'(row);
		if (col >= draw_w || y >= draw_h)
			return;

		if (depth == cbpb_pkg::DEPTH_32) begin
			nbytes = cbpb_pkg::BYTES_32;
			value  = red16 ? {px.red, px.green, px.blue} : {px.blue, px.green, px.red};
		end else if (depth == cbpb_pkg::DEPTH_16) begin
			nbytes = cbpb_pkg::BYTES_16;
			value  = {8'h00, px.red[7:3], px.green[7:2], px.blue[7:3]};
		end else begin
			return;
		end

		addr = 48'(off_y + y) * 48'(stride) + 48'(off_x + 13'(col)) * 48'(nbytes);
		wr.byte_address = addr[ADDR_W-1:0];
		wr.pixel_value  = value;
		wr.pixel_bytes  = nbytes;
		expected_writes.push_back(wr);
	endfunction

	function automatic void write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			cbpb_pkg::CFG_IMAGE_WIDTH:   img_w     = clamp_dim(val[DIM_W-1:0]);
			cbpb_pkg::CFG_IMAGE_HEIGHT:  img_h     = clamp_dim(val[DIM_W-1:0]);
			cbpb_pkg::CFG_ROWS_BOTTOM:   flip_rows = val[0];
			cbpb_pkg::CFG_SCREEN_WIDTH:  scr_w     = clamp_dim(val[DIM_W-1:0]);
			cbpb_pkg::CFG_SCREEN_HEIGHT: scr_h     = clamp_dim(val[DIM_W-1:0]);
			cbpb_pkg::CFG_LINE_STRIDE:   stride    = clamp_stride(val[STRIDE_W-1:0]);
			cbpb_pkg::CFG_DEST_DEPTH:    depth     = val[DEPTH_W-1:0];
			cbpb_pkg::CFG_RED_AT_BIT16:  red16     = val[0];
			default: ;	// unknown index: ignored
		endcase
	endfunction

	function automatic void check_write(input cbpb_pkg::pix_out_t got);
		cbpb_pkg::pix_out_t exp_wr;
		if (expected_writes.size() == 0) begin
			errs++;
			if (errs <= REPORT_MAX)
				$display("%t: unexpected write request addr=%0h value=%0h bytes=%0d",
					$realtime, got.byte_address, got.pixel_value, got.pixel_bytes);
			return;
		end
		exp_wr = expected_writes.pop_front();
		checked++;
		if (got.byte_address !== exp_wr.byte_address ||
				got.pixel_value !== exp_wr.pixel_value ||
				got.pixel_bytes !== exp_wr.pixel_bytes) begin
			errs++;
			if (errs <= REPORT_MAX)
				$display("%t: write mismatch: addr %0h/%0h value %0h/%0h bytes %0d/%0d (exp/got)",
					$realtime, exp_wr.byte_address, got.byte_address,
					exp_wr.pixel_value, got.pixel_value,
					exp_wr.pixel_bytes, got.pixel_bytes);
		end
	endfunction

	// watch the three channels; writes out are checked before new pixels queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w     = DIM_W'(1);
			img_h     = DIM_W'(1);
			flip_rows = 1'b1;
			scr_w     = DIM_W'(1);
			scr_h     = DIM_W'(1);
			stride    = STRIDE_W'(1);
			depth     = cbpb_pkg::DEPTH_32;
			red16     = 1'b1;
			src_col   = '0;
			src_row   = '0;
			expected_writes.delete();
			errs      = 0;
			checked   = 0;
		end else begin
			if (out_valid && out_ready)
				check_write(out_data);
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				place_pixel(in_data);
		end
		error_count    <= errs;
		pending_writes <= expected_writes.size();
		checked_writes <= checked;
	end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - top level for the centred bitmap blitter
// Drives pixel and register requests into the blitter with random gaps and
// write back-pressure, and gives the verdict from the checker's error count.
// A short directed run covers colour extremes, both depths, both 32-bit
// packings, clipping, centring and saturated registers; random settings
// with random pixels follow.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFG_INDEX_W = cbpb_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W  = cbpb_pkg::CFG_DATA_W;

	localparam int PIXEL_TARGET = 850;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [CFG_DATA_W-1:0] D16 = CFG_DATA_W'(cbpb_pkg::DEPTH_16);
	localparam logic [CFG_DATA_W-1:0] D32 = CFG_DATA_W'(cbpb_pkg::DEPTH_32);

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	cbpb_pkg::pix_in_t  in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	cbpb_pkg::pix_out_t out_data;

	int error_count, pending_writes, checked_writes;
	int cycle_count    = 0;
	int pixels_sent    = 0;
	int settings_done  = 0;
	bit steady         = 1'b0;

	always #5ns clk = ~clk;

	centered_bitmap_pixel_blitter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	blit_write_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.error_count    (error_count),
		.pending_writes (pending_writes),
		.checked_writes (checked_writes)
	);

	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < 15);
	endfunction

	// write back-pressure
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 15);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Run stopped at cycle limit with %0d writes outstanding", pending_writes);
		$display("centered_bitmap_pixel_blitter_unit verification failed");
		$finish;
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// whole register set in index order, sometimes with a stray unknown index
	task automatic apply_setting(input logic [CFG_DATA_W-1:0] iw, ih, bu, sw, sh,
			input logic [CFG_DATA_W-1:0] stride, depth, red16);
		write_reg(cbpb_pkg::CFG_IMAGE_WIDTH, iw);
		write_reg(cbpb_pkg::CFG_IMAGE_HEIGHT, ih);
		write_reg(cbpb_pkg::CFG_ROWS_BOTTOM, bu);
		if ($urandom_range(3) == 0)
			write_reg(CFG_INDEX_W'($urandom_range(8, 15)), CFG_DATA_W'($urandom));
		write_reg(cbpb_pkg::CFG_SCREEN_WIDTH, sw);
		write_reg(cbpb_pkg::CFG_SCREEN_HEIGHT, sh);
		write_reg(cbpb_pkg::CFG_LINE_STRIDE, stride);
		write_reg(cbpb_pkg::CFG_DEST_DEPTH, depth);
		write_reg(cbpb_pkg::CFG_RED_AT_BIT16, red16);
		settings_done++;
	endtask

	// valid stays up between back-to-back requests
	task automatic send_pixel(input cbpb_pkg::pix_in_t px);
		if (idle_now()) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while (idle_now());
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do
			@(posedge clk);
		while (!in_ready);
		pixels_sent++;
	endtask

	task automatic send_random(input int count);
		repeat (count)
			send_pixel(cbpb_pkg::pix_in_t'(24'($urandom)));
		in_valid <= 1'b0;
	endtask

	// all writes back, then let any invisible pixel leave the pipeline
	task automatic drain();
		@(posedge clk);
		while (pending_writes != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		int phase_no;
		int count;
		int pick;
		logic [CFG_DATA_W-1:0] iw, ih, sw, sh, stride, depth;

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: single pixel image, 32-bit BGRX
		send_pixel('{blue: 8'h00, green: 8'h00, red: 8'h00});
		send_pixel('{blue: 8'hFF, green: 8'hFF, red: 8'hFF});
		in_valid <= 1'b0;
		drain();

		// small centred image, RGB565, top-down rows
		apply_setting(15'd3, 15'd2, 15'd0, 15'd5, 15'd4, 15'd20, D16, 15'd0);
		send_pixel('{blue: 8'hFF, green: 8'h00, red: 8'h00});
		send_pixel('{blue: 8'h00, green: 8'hFF, red: 8'h00});
		send_pixel('{blue: 8'h00, green: 8'h00, red: 8'hFF});
		send_pixel('{blue: 8'h07, green: 8'h03, red: 8'h07});
		send_pixel('{blue: 8'hF8, green: 8'hFC, red: 8'hF8});
		send_pixel('{blue: 8'hFF, green: 8'hFF, red: 8'hFF});
		in_valid <= 1'b0;
		drain();

		// RGBX packing, bottom-up rows
		apply_setting(15'd2, 15'd2, 15'd1, 15'd2, 15'd2, 15'd8, D32, 15'd0);
		send_random(4);
		drain();

		// image larger than the screen: clipped; the row sent is its bottom row, which is cut off
		apply_setting(15'd4, 15'd4, 15'd1, 15'd2, 15'd3, 15'd4, D32, 15'd1);
		send_random(4);
		drain();

		// saturated registers, unsupported depth drops every pixel
		apply_setting(15'd0, 15'h7FFF, 15'd1, 15'h1FFF, 15'd0, 15'd0, 15'd63, 15'd1);
		write_reg(4'd15, 15'h7FFF);
		send_random(3);
		drain();
		apply_setting(15'd0, 15'h7FFF, 15'd1, 15'h1FFF, 15'd0, 15'h7FFF, 15'd0, 15'd1);
		send_random(2);
		drain();

		// largest sizes and stride: addresses near the top of the range
		apply_setting(15'h1000, 15'h1000, 15'd1, 15'h1000, 15'h1000, 15'd16384, D32, 15'd1);
		send_random(4);
		drain();

		// random settings and pixels
		phase_no = 0;
		while (pixels_sent < PIXEL_TARGET) begin
			steady = (phase_no >= 10 && phase_no < 18);
			if ($urandom_range(7) == 0) begin
				iw     = CFG_DATA_W'($urandom);
				ih     = ($urandom_range(1) != 0) ? CFG_DATA_W'($urandom)
					: CFG_DATA_W'($urandom_range(4096));
				sw     = CFG_DATA_W'($urandom_range(8191));
				sh     = CFG_DATA_W'($urandom_range(8191));
				stride = CFG_DATA_W'($urandom);
				count  = int'($urandom_range(5, 30));
			end else begin
				iw     = CFG_DATA_W'($urandom_range(1, 8));
				ih     = CFG_DATA_W'($urandom_range(1, 6));
				sw     = CFG_DATA_W'($urandom_range(1, 10));
				sh     = CFG_DATA_W'($urandom_range(1, 8));
				stride = ($urandom_range(5) == 0) ? CFG_DATA_W'($urandom)
					: CFG_DATA_W'($urandom_range(1, 64));
				count  = int'(iw) * int'(ih) * int'($urandom_range(1, 2))
					+ int'($urandom_range(3));
				if (count > 60)
					count = 60;
			end
			pick = int'($urandom_range(9));
			if (pick < 4)
				depth = D16;
			else if (pick < 8)
				depth = D32;
			else
				depth = CFG_DATA_W'($urandom);
			apply_setting(iw, ih, CFG_DATA_W'($urandom), sw, sh, stride, depth,
				CFG_DATA_W'($urandom));
			send_random(count);
			drain();
			phase_no++;
		end
		steady = 1'b0;
		drain();

		$display("Sent %0d pixel requests under %0d register settings;", pixels_sent,
			settings_done);
		$display("%0d framebuffer write requests compared, %0d errors.", checked_writes,
			error_count);
		if (error_count == 0 && pending_writes == 0)
			$display("centered_bitmap_pixel_blitter_unit verification clean");
		else
			$display("centered_bitmap_pixel_blitter_unit verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/cbpb_pkg.sv
rtl/cbpb_cfg.sv
rtl/cbpb_place.sv
rtl/cbpb_addr.sv
rtl/centered_bitmap_pixel_blitter_unit.sv
sim/blit_write_checker.sv
sim/testbench.sv
